// ===== src/hcb_pkg.sv =====
// Shared types and constants for the Huffman code builder.
package hcb_pkg;

	typedef enum logic [1:0] {
		OP_CLEAR  = 2'd0,
		OP_LOAD   = 2'd1,
		OP_BUILD  = 2'd2,
		OP_LOOKUP = 2'd3
	} op_t;

	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_OVERLONG = 2'd1;
	localparam logic [1:0] ST_ORDER    = 2'd2;

	localparam int SYM_BITS  = 8;
	localparam int SYM_COUNT = 256;
	localparam int CNT_BITS  = 9;
	localparam int FREQ_W    = 32;
	localparam int LEN_BITS  = 6;
	localparam int CODE_W    = 48;

	typedef struct packed {
		logic [1:0]          op;
		logic [SYM_BITS-1:0] symbol;
		logic [FREQ_W-1:0]   frequency;
	} in_item_t;

	typedef struct packed {
		logic [1:0]          status;
		logic [CNT_BITS-1:0] leaf_count;
		logic                present;
		logic [LEN_BITS-1:0] code_length;
		logic [CODE_W-1:0]   code_bits;
	} out_item_t;

	// Controller commands to the datapath.
	typedef struct packed {
		logic load_leaf;
		logic clear;
		logic merge_step;
		logic merge_init;
		logic walk_init;
		logic walk_rd;
		logic walk_wr;
		logic emit_rd;
		logic emit_wr;
		logic single;
		logic look_rd;
		logic build_clr;
	} hcb_cmd_t;

	typedef struct packed {
		logic merge_done;
		logic walk_done;
		logic emit_done;
		logic few_leaves;
	} hcb_stat_t;

endpackage

// ===== src/hcb_ram.sv =====
// Generic single-port-write, one-read RAM with registered read data.
module hcb_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

// ===== src/hcb_datapath.sv =====
// Datapath: leaf, merged-node and code stores, merge and walk arithmetic.
module hcb_datapath #(
	parameter int MAX_SYMBOLS   = 256,
	parameter int FREQ_BITS     = 32,
	parameter int MAX_CODE_BITS = 48
) (
	input  logic                clk,
	input  logic                arst_n,
	input  hcb_pkg::in_item_t   item,
	input  hcb_pkg::hcb_cmd_t   cmd,
	output hcb_pkg::hcb_stat_t  stat,
	output hcb_pkg::out_item_t  result
);
	localparam int LI_BITS = $clog2(MAX_SYMBOLS);
	localparam int NODES   = 2 * MAX_SYMBOLS - 1;
	localparam int ND_BITS = $clog2(NODES);
	localparam int W_BITS  = FREQ_BITS + 8;
	localparam int DEP_BITS = $clog2(MAX_SYMBOLS + 1);
	localparam int CODE_STORE = (MAX_CODE_BITS > hcb_pkg::CODE_W) ?
		MAX_CODE_BITS : hcb_pkg::CODE_W;

	// leaf store: weight and symbol
	logic [hcb_pkg::CNT_BITS-1:0] count_q;
	logic [1:0]                   status_q;
	logic [FREQ_BITS-1:0]         last_w_q;
	logic [hcb_pkg::SYM_COUNT-1:0] valid_q;

	logic [FREQ_BITS-1:0] freq_m;
	assign freq_m = item.frequency[FREQ_BITS-1:0];

	logic                  lw_we;
	logic [LI_BITS-1:0]    lw_waddr, lw_raddr;
	logic [FREQ_BITS-1:0]  lw_rdata;
	logic [hcb_pkg::SYM_BITS-1:0] ls_rdata;
	logic [LI_BITS-1:0]    ls_raddr;

	assign lw_we    = cmd.load_leaf && freq_m != '0 && count_q < MAX_SYMBOLS;
	assign lw_waddr = count_q[LI_BITS-1:0];

	hcb_ram #(.WIDTH(FREQ_BITS), .DEPTH(MAX_SYMBOLS)) u_lw (
		.clk, .we(lw_we), .waddr(lw_waddr), .wdata(freq_m),
		.raddr(lw_raddr), .rdata(lw_rdata));
	hcb_ram #(.WIDTH(hcb_pkg::SYM_BITS), .DEPTH(MAX_SYMBOLS)) u_ls (
		.clk, .we(lw_we), .waddr(lw_waddr), .wdata(item.symbol),
		.raddr(ls_raddr), .rdata(ls_rdata));

	// merge: heads of both queues come straight from the registered RAM reads
	logic [LI_BITS:0]   li_q, ii_q, k_q;
	logic [W_BITS-1:0]  lhead, ihead, acc_q;
	logic               pick_q;   // second pick of the current merge

	logic [W_BITS-1:0]  iw_rdata, iw_wdata;
	logic [LI_BITS-1:0] iw_raddr, iw_waddr;
	logic               iw_we;

	// The controller puts an idle S_MWAIT state between merge steps; that state reads the
	// heads at the current indexes, after any merged weight written by the last step.
	assign lhead = W_BITS'(lw_rdata);
	assign ihead = iw_rdata;

	logic take_leaf;
	assign take_leaf = (li_q < count_q) &&
		(ii_q >= k_q || lhead < ihead);

	logic [ND_BITS-1:0] n_nodes;
	assign n_nodes = ND_BITS'(count_q);

	logic [ND_BITS-1:0] pick_node;
	logic [W_BITS-1:0]  pick_w;
	always_comb begin
		if (take_leaf) begin
			pick_node = ND_BITS'(li_q);
			pick_w    = lhead;
		end else begin
			pick_node = ND_BITS'(n_nodes + ND_BITS'(ii_q));
			pick_w    = ihead;
		end
	end

	// node parent and branch bit store, packed into one word
	logic               np_we;
	logic [ND_BITS-1:0] np_waddr, np_raddr;
	logic [ND_BITS:0]   np_wdata, np_rdata;

	assign iw_we    = cmd.merge_step && pick_q;
	assign iw_waddr = k_q[LI_BITS-1:0];
	assign iw_wdata = acc_q + pick_w;
	assign np_we    = cmd.merge_step;
	assign np_waddr = pick_node;
	assign np_wdata = {ND_BITS'(n_nodes + ND_BITS'(k_q)), !pick_q};

	hcb_ram #(.WIDTH(W_BITS), .DEPTH(MAX_SYMBOLS)) u_iw (
		.clk, .we(iw_we), .waddr(iw_waddr), .wdata(iw_wdata),
		.raddr(iw_raddr), .rdata(iw_rdata));

	// Read addresses follow the index after this step.
	logic [LI_BITS:0] li_nx, ii_nx;
	always_comb begin
		li_nx = li_q;
		ii_nx = ii_q;
		if (cmd.merge_step) begin
			if (take_leaf) li_nx = li_q + 1'b1;
			else           ii_nx = ii_q + 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			li_q <= '0; ii_q <= '0; k_q <= '0; pick_q <= 1'b0;
		end else begin
			if (cmd.merge_init) begin
				li_q <= '0; ii_q <= '0; k_q <= '0; pick_q <= 1'b0;
			end else if (cmd.merge_step) begin
				li_q   <= li_nx;
				ii_q   <= ii_nx;
				pick_q <= !pick_q;
				if (pick_q) k_q <= k_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.merge_step && !pick_q) begin
			acc_q <= pick_w;
		end
	end

	assign stat.merge_done = (k_q + 1'b1 >= count_q) && !pick_q;
	assign stat.few_leaves = count_q < 2;

	// walk: nodes from root-1 down to 0, each reading its parent's depth and code
	logic [ND_BITS-1:0] v_q, root;
	assign root = ND_BITS'(2 * count_q - 2);

	logic                        nd_we;
	logic [ND_BITS-1:0]          nd_raddr;
	logic [DEP_BITS+CODE_STORE-1:0] nd_wdata, nd_rdata;

	logic [ND_BITS-1:0] par;
	logic [DEP_BITS-1:0]   p_dep;
	logic [CODE_STORE-1:0] p_code;
	always_comb begin
		par = np_rdata[ND_BITS:1];
		if (par > root || par <= v_q) par = root;
	end
	assign nd_raddr = (cmd.walk_rd) ? par : np_raddr;
	assign p_dep  = (par == root) ? '0 : nd_rdata[DEP_BITS+CODE_STORE-1:CODE_STORE];
	assign p_code = (par == root) ? '0 : nd_rdata[CODE_STORE-1:0];
	assign nd_we    = cmd.walk_wr;
	assign nd_wdata = {DEP_BITS'(p_dep + 1'b1), p_code[CODE_STORE-2:0], np_rdata[0]};

	always_comb begin
		np_raddr = v_q;
		lw_raddr = li_nx[LI_BITS-1:0];
		iw_raddr = ii_nx[LI_BITS-1:0];
		ls_raddr = v_q[LI_BITS-1:0];
	end

	hcb_ram #(.WIDTH(ND_BITS + 1), .DEPTH(NODES)) u_np (
		.clk, .we(np_we), .waddr(np_waddr), .wdata(np_wdata),
		.raddr(np_raddr), .rdata(np_rdata));
	hcb_ram #(.WIDTH(DEP_BITS + CODE_STORE), .DEPTH(NODES)) u_nd (
		.clk, .we(nd_we), .waddr(v_q), .wdata(nd_wdata),
		.raddr(nd_raddr), .rdata(nd_rdata));

	assign stat.walk_done = (v_q == '0);
	// an empty table emits nothing
	assign stat.emit_done = (count_q == '0) || (v_q == ND_BITS'(count_q - 1'b1));

	always_ff @(posedge clk) begin
		if (cmd.walk_init)     v_q <= ND_BITS'(root - 1'b1);
		else if (cmd.walk_wr && v_q != '0) v_q <= v_q - 1'b1;
		else if (cmd.merge_init) v_q <= '0;
		else if (cmd.emit_wr)  v_q <= v_q + 1'b1;
	end

	// symbol code store
	logic [DEP_BITS-1:0]   e_dep;
	logic [CODE_STORE-1:0] e_code;
	logic                  e_ok;
	logic                  emit_en;
	assign e_dep   = nd_rdata[DEP_BITS+CODE_STORE-1:CODE_STORE];
	assign e_code  = nd_rdata[CODE_STORE-1:0];
	assign e_ok    = cmd.single || e_dep <= MAX_CODE_BITS;
	assign emit_en = cmd.emit_wr && count_q != '0;

	logic [hcb_pkg::SYM_BITS-1:0] sc_addr;
	logic sc_we;
	logic [hcb_pkg::LEN_BITS+hcb_pkg::CODE_W-1:0] sc_wdata, sc_rdata;
	assign sc_we    = emit_en && e_ok;
	assign sc_addr  = cmd.emit_wr ? ls_rdata : item.symbol;
	assign sc_wdata = cmd.single ? '0 :
		{hcb_pkg::LEN_BITS'(e_dep), hcb_pkg::CODE_W'(e_code)};

	hcb_ram #(.WIDTH(hcb_pkg::LEN_BITS + hcb_pkg::CODE_W), .DEPTH(hcb_pkg::SYM_COUNT)) u_sc (
		.clk, .we(sc_we), .waddr(sc_addr), .wdata(sc_wdata),
		.raddr(sc_addr), .rdata(sc_rdata));

	logic look_valid_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0; status_q <= hcb_pkg::ST_OK; valid_q <= '0; look_valid_q <= 1'b0;
		end else begin
			if (cmd.clear) begin
				count_q <= '0; status_q <= hcb_pkg::ST_OK; valid_q <= '0;
			end
			if (lw_we) begin
				count_q <= count_q + 1'b1;
				if (count_q != '0 && freq_m < last_w_q) status_q <= hcb_pkg::ST_ORDER;
			end
			if (cmd.build_clr) valid_q <= '0;
			if (emit_en) begin
				valid_q[ls_rdata] <= e_ok;
				if (!e_ok && status_q == hcb_pkg::ST_OK) status_q <= hcb_pkg::ST_OVERLONG;
			end
			// a build beat reports no code
			if (cmd.look_rd) look_valid_q <= valid_q[item.symbol];
			else if (cmd.build_clr) look_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (lw_we) last_w_q <= freq_m;
	end

	always_comb begin
		result.status      = status_q;
		result.leaf_count  = count_q;
		result.present     = look_valid_q;
		result.code_length = look_valid_q ? sc_rdata[hcb_pkg::LEN_BITS+hcb_pkg::CODE_W-1:
			hcb_pkg::CODE_W] : '0;
		result.code_bits   = look_valid_q ? sc_rdata[hcb_pkg::CODE_W-1:0] : '0;
	end
endmodule

// ===== src/hcb_ctrl.sv =====
// Controller state machine: sequences load, build, walk, code emit and lookup.
module hcb_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [1:0]         in_op,
	output logic               out_valid,
	input  logic               out_ready,
	output logic               cap,
	input  hcb_pkg::hcb_stat_t stat,
	output hcb_pkg::hcb_cmd_t  cmd
);
	typedef enum logic [10:0] {
		S_IDLE  = 11'b00000000001,
		S_MINIT = 11'b00000000010,
		S_MWAIT = 11'b00000000100,
		S_MSTEP = 11'b00000001000,
		S_WRD   = 11'b00000010000,
		S_WPAR  = 11'b00000100000,
		S_WWR   = 11'b00001000000,
		S_ERD   = 11'b00010000000,
		S_EWR   = 11'b00100000000,
		S_RES   = 11'b01000000000,
		S_LOOK  = 11'b10000000000
	} state_t;

	state_t state_q, state_d;
	logic   single_q;
	logic   busy;
	logic   accept;

	assign busy     = state_q != S_IDLE;
	assign in_ready = !busy && !out_valid;
	assign accept   = in_valid && in_ready;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		cap     = 1'b0;
		cmd.single = single_q;
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					unique case (hcb_pkg::op_t'(in_op))
						hcb_pkg::OP_CLEAR: cmd.clear = 1'b1;
						hcb_pkg::OP_LOAD:  cmd.load_leaf = 1'b1;
						hcb_pkg::OP_BUILD: begin
							cmd.build_clr  = 1'b1;
							cmd.merge_init = 1'b1;
							state_d = S_MINIT;
						end
						hcb_pkg::OP_LOOKUP: begin
							cmd.look_rd = 1'b1;
							state_d = S_LOOK;
						end
						default: ;
					endcase
				end
			end
			S_MINIT: state_d = stat.few_leaves ? S_ERD : S_MWAIT;
			S_MWAIT: state_d = S_MSTEP;
			S_MSTEP: begin
				cmd.merge_step = 1'b1;
				state_d = stat.merge_done ? S_WRD : S_MWAIT;
				if (stat.merge_done) cmd.walk_init = 1'b1;
			end
			S_WRD:  state_d = S_WPAR;
			S_WPAR: begin
				cmd.walk_rd = 1'b1;
				state_d = S_WWR;
			end
			S_WWR: begin
				cmd.walk_wr = 1'b1;
				state_d = stat.walk_done ? S_ERD : S_WRD;
				if (stat.walk_done) cmd.merge_init = 1'b1;
			end
			S_ERD: begin
				cmd.emit_rd = 1'b1;
				state_d = S_EWR;
			end
			S_EWR: begin
				cmd.emit_wr = 1'b1;
				state_d = stat.emit_done ? S_RES : S_ERD;
			end
			S_RES:  begin
				cap = 1'b1;
				state_d = S_IDLE;
			end
			S_LOOK: begin
				cap = 1'b1;
				state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			out_valid <= 1'b0;
			single_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == S_MINIT) single_q <= stat.few_leaves;
			if (cap) out_valid <= 1'b1;
			else if (out_valid && out_ready) out_valid <= 1'b0;
		end
	end
endmodule

// ===== src/huffman_code_builder.sv =====
// Huffman code builder, two-queue merge with registered lookup.
// Clear and load are done in the idle state on the accepting beat and give no result.
// A lookup reads the code store on its beat; in S_LOOK the result is captured into the
// output register and out_valid is set. A build merges the leaves into a tree, walks
// the nodes over the node RAMs and then writes the symbol codes. One item is in work
// at a time; the result sits in an output register until taken.
module huffman_code_builder #(
	parameter int MAX_SYMBOLS   = 256,
	parameter int FREQ_BITS     = 32,
	parameter int MAX_CODE_BITS = 48
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  hcb_pkg::in_item_t  in_item,
	output logic               out_valid,
	input  logic               out_ready,
	output hcb_pkg::out_item_t out_item
);
	hcb_pkg::hcb_cmd_t  cmd;
	hcb_pkg::hcb_stat_t stat;
	hcb_pkg::out_item_t res;
	logic               cap;

	hcb_ctrl u_ctrl (
		.clk, .arst_n, .in_valid, .in_ready, .in_op(in_item.op),
		.out_valid, .out_ready, .cap, .stat, .cmd);

	hcb_datapath #(
		.MAX_SYMBOLS(MAX_SYMBOLS), .FREQ_BITS(FREQ_BITS), .MAX_CODE_BITS(MAX_CODE_BITS)
	) u_dp (
		.clk, .arst_n, .item(in_item), .cmd, .stat, .result(res));

	always_ff @(posedge clk) begin
		if (cap) out_item <= res;
	end
endmodule

// ===== src/hcb_checker.sv =====
// Port-level checker for the Huffman code builder.
module hcb_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               in_valid,
	input logic               in_ready,
	input logic               out_valid,
	input logic               out_ready,
	input hcb_pkg::out_item_t out_item
);
	a_no_accept_while_full: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !in_ready) else $error("input taken while result pending");
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_item))
		else $error("result changed before beat");
	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_item.status <= hcb_pkg::ST_ORDER) else $error("bad status");
	a_absent_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_item.present |-> out_item.code_length == '0)
		else $error("length without code");
endmodule

bind huffman_code_builder hcb_checker u_hcb_checker (
	.clk, .arst_n, .in_valid, .in_ready, .out_valid, .out_ready, .out_item);
